### rtl/kme_pkg.sv
// Package: action and status codes of the key macro expander.
`default_nettype none
package kme_pkg;

    localparam logic [1:0] ACT_OPEN   = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [2:0] ST_FUNC    = 3'd0;
    localparam logic [2:0] ST_NOMATCH = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ACCEPT  = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;

    localparam int KEY_W    = 16;
    localparam int FUNC_W   = 16;
    localparam int GRP_W    = 5;

    typedef logic [1:0]        action_t;
    typedef logic [2:0]        status_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [GRP_W-1:0]  grp_t;

endpackage
`default_nettype wire

### rtl/kme_cmd_if.sv
// Interface: input item channel of the key macro expander.
`default_nettype none
interface kme_cmd_if;
    logic             valid;
    logic             ready;
    kme_pkg::action_t action;
    kme_pkg::key_t    key_code;
    kme_pkg::func_t   func_code;

    modport source (output valid, output action, output key_code, output func_code,
                    input ready);
    modport sink   (input valid, input action, input key_code, input func_code,
                    output ready);
endinterface
`default_nettype wire

### rtl/kme_res_if.sv
// Interface: result item channel of the key macro expander.
`default_nettype none
interface kme_res_if;
    logic             valid;
    logic             ready;
    kme_pkg::status_t status;
    kme_pkg::func_t   func_out;
    kme_pkg::grp_t    group_index;
    logic             last;

    modport source (output valid, output status, output func_out, output group_index,
                    output last, input ready);
    modport sink   (input valid, input status, input func_out, input group_index,
                    input last, output ready);
endinterface
`default_nettype wire

### rtl/key_macro_expander.sv
// Key macro expander: group table in memories, sequential lookup and code emission.
// Open, append and clear items: the result is loaded into the output register when the item is accepted.
// Lookup: each group scanned takes a group memory read, then a compare; each emitted
// function code takes a function memory read, then an output register load.
// One item in flight; the next is taken once the output register is free again.
// Reset clears the group count, open flag, open length, next base, FSM and output valid; no clearing pass.
`default_nettype none
module key_macro_expander #(
    parameter int MAX_GROUPS = 32,
    parameter int QUEUE_LEN  = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    kme_cmd_if.sink   cmd,
    kme_res_if.source res
);

    localparam int GW   = $clog2(MAX_GROUPS + 1);
    localparam int AW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int LW   = $clog2(QUEUE_LEN);
    localparam int FD   = MAX_GROUPS * QUEUE_LEN;
    localparam int FAW  = $clog2(FD);
    localparam int FBW  = $clog2(FD + 1);
    localparam int XW   = GW + kme_pkg::GRP_W;
    localparam int GMW  = kme_pkg::KEY_W + LW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_WR = 3'd4;
    localparam logic [2:0] S_ONE     = 3'd5;

    // memories: {key, length} per group, function codes per group slot
    logic [GMW-1:0]             gmem [MAX_GROUPS];
    logic [kme_pkg::FUNC_W-1:0] fmem [FD];

    logic [2:0]           state_reg, state_next;
    logic [GW-1:0]        total_reg, total_next;
    logic                 open_reg, open_next;
    logic [kme_pkg::KEY_W-1:0] cur_key_reg, cur_key_next;
    logic [LW-1:0]        cur_len_reg, cur_len_next;
    logic [FBW-1:0]       cur_base_reg, cur_base_next;
    logic [FBW-1:0]       next_base_reg, next_base_next;
    logic [kme_pkg::KEY_W-1:0] look_key_reg, look_key_next;
    logic [GW-1:0]        scan_idx_reg, scan_idx_next;
    logic [FBW-1:0]       scan_base_reg, scan_base_next;
    logic [LW-1:0]        emit_len_reg, emit_len_next;
    logic [LW-1:0]        emit_i_reg, emit_i_next;
    kme_pkg::status_t     pend_status_reg, pend_status_next;
    kme_pkg::grp_t        pend_grp_reg, pend_grp_next;

    logic                 out_valid_reg, out_valid_next;
    kme_pkg::status_t     out_status_reg, out_status_next;
    kme_pkg::func_t       out_func_reg, out_func_next;
    kme_pkg::grp_t        out_grp_reg, out_grp_next;
    logic                 out_last_reg, out_last_next;

    logic                 g_we, g_re, f_we, f_re;
    logic [AW-1:0]        g_waddr;
    logic [GMW-1:0]       g_wdata;
    logic [FAW-1:0]       f_waddr, f_raddr;
    logic [kme_pkg::FUNC_W-1:0] f_wdata;
    logic [GMW-1:0]       g_rdata_reg;
    logic [kme_pkg::FUNC_W-1:0] f_rdata_reg;

    logic                 out_free, accept;
    logic [GW-1:0]        cur_grp;
    kme_pkg::grp_t        total5, cur5, scan5;
    logic [XW-1:0]        total_x, cur_x, scan_x;
    logic [kme_pkg::KEY_W-1:0] rd_key;
    logic [LW-1:0]        rd_len;

    assign out_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept = cmd.valid && cmd.ready;

    assign cur_grp = total_reg - GW'(1);
    assign total_x = XW'(total_reg);
    assign cur_x   = XW'(cur_grp);
    assign scan_x  = XW'(scan_idx_reg);
    assign total5  = total_x[kme_pkg::GRP_W-1:0];
    assign cur5    = cur_x[kme_pkg::GRP_W-1:0];
    assign scan5   = scan_x[kme_pkg::GRP_W-1:0];

    assign rd_key = g_rdata_reg[GMW-1:LW];
    assign rd_len = g_rdata_reg[LW-1:0];

    assign f_raddr = FAW'(scan_base_reg + FBW'(emit_i_reg));

    always_comb
    begin
        state_next       = state_reg;
        total_next       = total_reg;
        open_next        = open_reg;
        cur_key_next     = cur_key_reg;
        cur_len_next     = cur_len_reg;
        cur_base_next    = cur_base_reg;
        next_base_next   = next_base_reg;
        look_key_next    = look_key_reg;
        scan_idx_next    = scan_idx_reg;
        scan_base_next   = scan_base_reg;
        emit_len_next    = emit_len_reg;
        emit_i_next      = emit_i_reg;
        pend_status_next = pend_status_reg;
        pend_grp_next    = pend_grp_reg;

        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_func_next   = out_func_reg;
        out_grp_next    = out_grp_reg;
        out_last_next   = out_last_reg;

        g_we    = 1'b0;
        g_re    = 1'b0;
        f_we    = 1'b0;
        f_re    = 1'b0;
        g_waddr = cur_grp[AW-1:0];
        g_wdata = {cur_key_reg, LW'(cur_len_reg + LW'(1))};
        f_waddr = FAW'(cur_base_reg + FBW'(cur_len_reg));
        f_wdata = cmd.func_code;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_func_next = '0;
                    out_last_next = 1'b1;
                    out_grp_next  = '0;
                    unique case (cmd.action)
                        kme_pkg::ACT_OPEN:
                        begin
                            if (cmd.key_code == '0 || total_reg >= GW'(MAX_GROUPS))
                            begin
                                open_next       = 1'b0;
                                out_valid_next  = 1'b1;
                                out_status_next = kme_pkg::ST_REJECT;
                            end
                            else
                            begin
                                g_we            = 1'b1;
                                g_waddr         = total_reg[AW-1:0];
                                g_wdata         = {cmd.key_code, LW'(0)};
                                cur_key_next    = cmd.key_code;
                                cur_len_next    = '0;
                                cur_base_next   = next_base_reg;
                                next_base_next  = next_base_reg + FBW'(QUEUE_LEN);
                                total_next      = total_reg + GW'(1);
                                open_next       = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = kme_pkg::ST_ACCEPT;
                                out_grp_next    = total5;
                            end
                        end
                        kme_pkg::ACT_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (!open_reg)
                            begin
                                out_status_next = kme_pkg::ST_REJECT;
                            end
                            else if (cur_len_reg >= LW'(QUEUE_LEN - 1))
                            begin
                                out_status_next = kme_pkg::ST_REJECT;
                                out_grp_next    = cur5;
                            end
                            else
                            begin
                                g_we            = 1'b1;
                                f_we            = 1'b1;
                                cur_len_next    = cur_len_reg + LW'(1);
                                out_status_next = kme_pkg::ST_ACCEPT;
                                out_grp_next    = cur5;
                            end
                        end
                        kme_pkg::ACT_LOOKUP:
                        begin
                            look_key_next  = cmd.key_code;
                            scan_idx_next  = '0;
                            scan_base_next = '0;
                            state_next     = S_SCAN;
                        end
                        kme_pkg::ACT_CLEAR:
                        begin
                            total_next      = '0;
                            open_next       = 1'b0;
                            next_base_next  = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = kme_pkg::ST_ACCEPT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg >= total_reg)
                begin
                    pend_status_next = kme_pkg::ST_NOMATCH;
                    pend_grp_next    = '0;
                    state_next       = S_ONE;
                end
                else
                begin
                    g_re       = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_key == look_key_reg)
                begin
                    if (rd_len == '0)
                    begin
                        pend_status_next = kme_pkg::ST_EMPTY;
                        pend_grp_next    = scan5;
                        state_next       = S_ONE;
                    end
                    else
                    begin
                        emit_len_next = rd_len;
                        emit_i_next   = '0;
                        state_next    = S_EMIT_RD;
                    end
                end
                else
                begin
                    scan_idx_next  = scan_idx_reg + GW'(1);
                    scan_base_next = scan_base_reg + FBW'(QUEUE_LEN);
                    state_next     = S_SCAN;
                end
            end
            S_EMIT_RD:
            begin
                f_re       = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = kme_pkg::ST_FUNC;
                    out_func_next   = f_rdata_reg;
                    out_grp_next    = scan5;
                    out_last_next   = (emit_i_reg + LW'(1)) == emit_len_reg;
                    if ((emit_i_reg + LW'(1)) == emit_len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_i_next = emit_i_reg + LW'(1);
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_func_next   = '0;
                    out_grp_next    = pend_grp_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gmem[g_waddr] <= g_wdata;
        end
        if (g_re)
        begin
            g_rdata_reg <= gmem[scan_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fmem[f_waddr] <= f_wdata;
        end
        if (f_re)
        begin
            f_rdata_reg <= fmem[f_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            open_reg      <= 1'b0;
            cur_len_reg   <= '0;
            next_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            open_reg      <= open_next;
            cur_len_reg   <= cur_len_next;
            next_base_reg <= next_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_key_reg     <= cur_key_next;
        cur_base_reg    <= cur_base_next;
        look_key_reg    <= look_key_next;
        scan_idx_reg    <= scan_idx_next;
        scan_base_reg   <= scan_base_next;
        emit_len_reg    <= emit_len_next;
        emit_i_reg      <= emit_i_next;
        pend_status_reg <= pend_status_next;
        pend_grp_reg    <= pend_grp_next;
        out_status_reg  <= out_status_next;
        out_func_reg    <= out_func_next;
        out_grp_reg     <= out_grp_next;
        out_last_reg    <= out_last_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.func_out    = out_func_reg;
    assign res.group_index = out_grp_reg;
    assign res.last        = out_last_reg;

`ifndef SYNTHESIS
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= GW'(MAX_GROUPS))
        else $error("group count above table size");

    a_open_has_group: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> total_reg != '0)
        else $error("open group flag with empty table");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= LW'(QUEUE_LEN - 1))
        else $error("open group length above limit");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.ready)
        else $error("item accepted during lookup");

    a_load_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.action != kme_pkg::ACT_LOOKUP) |=> (out_valid_reg && out_last_reg))
        else $error("load item without result");
`endif

endmodule
`default_nettype wire
